// ===== src/fe_element_gather_address_gen_assert.svh =====
// Assertion macros shared by the address generator RTL files.
`ifndef FE_ELEMENT_GATHER_ADDRESS_GEN_ASSERT_SVH
`define FE_ELEMENT_GATHER_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define FEGAG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fegag check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define FEGAG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fegag check failed");

`endif

// ===== src/fegag_pkg.sv =====
// Shared types, constants and helpers for the element gather address generator.
`default_nettype none

package fegag_pkg;

    localparam int MAX_POINTS_PER_DIM = 4;
    localparam int MAX_GRID_DIM       = 1024;

    localparam int ELEM_W      = 10;
    localparam int BASE_W      = 12;
    localparam int COORD_W     = BASE_W + 1;
    localparam int CNT_W       = $clog2(MAX_POINTS_PER_DIM);
    localparam int PTS_W       = 3;
    localparam int GRID_W      = 11;
    localparam int PLANE_W     = 2 * GRID_W - 1;
    localparam int ADDR_W      = 30;
    localparam int SLOT_W      = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = GRID_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINTS_X    = 3'd0,
        REG_POINTS_Y    = 3'd1,
        REG_POINTS_Z    = 3'd2,
        REG_GRID_SIZE_X = 3'd3,
        REG_GRID_SIZE_Y = 3'd4,
        REG_GRID_SIZE_Z = 3'd5,
        REG_TILED_MODE  = 3'd6
    } cfg_reg_t;

    // One queued element: start coordinate along each axis.
    typedef struct packed {
        logic [BASE_W-1:0] base_x;
        logic [BASE_W-1:0] base_y;
        logic [BASE_W-1:0] base_z;
    } elem_t;

    // Settings the front needs to place an element.
    typedef struct packed {
        logic [PTS_W-1:0] pts_x;
        logic [PTS_W-1:0] pts_y;
        logic [PTS_W-1:0] pts_z;
        logic             tiled;
    } front_cfg_t;

    // Settings the back needs to walk and address the points.
    typedef struct packed {
        logic [CNT_W-1:0]   last_x;
        logic [CNT_W-1:0]   last_y;
        logic [CNT_W-1:0]   last_z;
        logic [GRID_W-1:0]  size_x;
        logic [GRID_W-1:0]  size_y;
        logic [GRID_W-1:0]  size_z;
        logic [PLANE_W-1:0] plane;
    } back_cfg_t;

    // Zero reads as one point, anything above the limit saturates.
    function automatic logic [PTS_W-1:0] clamp_points(input logic [PTS_W-1:0] p);
        logic [PTS_W-1:0] r;
        if (p == '0)
            r = PTS_W'(1);
        else if (p > PTS_W'(MAX_POINTS_PER_DIM))
            r = PTS_W'(MAX_POINTS_PER_DIM);
        else
            r = p;
        return r;
    endfunction

    function automatic logic [GRID_W-1:0] clamp_grid(input logic [GRID_W-1:0] g);
        logic [GRID_W-1:0] r;
        if (g == '0)
            r = GRID_W'(1);
        else if (g > GRID_W'(MAX_GRID_DIM))
            r = GRID_W'(MAX_GRID_DIM);
        else
            r = g;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/fegag_front.sv =====
// Front end: takes element beats and turns them into start coordinates.
`default_nettype none

module fegag_front (
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [fegag_pkg::ELEM_W-1:0]      element_x,
    input  logic [fegag_pkg::ELEM_W-1:0]      element_y,
    input  logic [fegag_pkg::ELEM_W-1:0]      element_z,
    input  fegag_pkg::front_cfg_t             cfg,
    input  logic                              full,
    output logic                              push,
    output fegag_pkg::elem_t                  entry
);
    import fegag_pkg::*;

    // Nodal elements share a face (stride points-1), tiled ones do not.
    function automatic logic [BASE_W-1:0] elem_start(
        input logic [ELEM_W-1:0] id,
        input logic [PTS_W-1:0]  pts,
        input logic              tiled
    );
        logic [PTS_W-1:0]        stride;
        logic [ELEM_W+PTS_W-1:0] prod;
        stride = tiled ? pts : pts - PTS_W'(1);
        prod   = id * stride;
        return prod[BASE_W-1:0];
    endfunction

    assign item_stall = full;
    assign push       = item_valid && !full;

    assign entry.base_x = elem_start(element_x, cfg.pts_x, cfg.tiled);
    assign entry.base_y = elem_start(element_y, cfg.pts_y, cfg.tiled);
    assign entry.base_z = elem_start(element_z, cfg.pts_z, cfg.tiled);

endmodule

`default_nettype wire

// ===== src/fegag_queue.sv =====
// Short element queue between the front and the back end.
`default_nettype none

`include "fe_element_gather_address_gen_assert.svh"

module fegag_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fegag_pkg::elem_t entry,
    input  logic             pop,
    output fegag_pkg::elem_t head,
    output logic             full,
    output logic             empty
);
    import fegag_pkg::*;

    elem_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= entry;
    end

    `FEGAG_ASSERT_IMPL(a_no_push_when_full, push, !full)
    `FEGAG_ASSERT_IMPL(a_no_pop_when_empty, pop, !empty)
    `FEGAG_ASSERT_IMPL(a_empty_ptrs_agree, empty, wr_ptr_reg == rd_ptr_reg)

endmodule

`default_nettype wire

// ===== src/fegag_back.sv =====
// Back end: walks the points of the head element and computes their addresses.
`default_nettype none

`include "fe_element_gather_address_gen_assert.svh"

module fegag_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fegag_pkg::back_cfg_t           cfg,
    input  fegag_pkg::elem_t               head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [fegag_pkg::ADDR_W-1:0]   address,
    output logic [fegag_pkg::SLOT_W-1:0]   local_slot,
    output logic                           outside,
    output logic                           last
);
    import fegag_pkg::*;

    // point counters for the head element
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;

    // stage 1: point coordinate
    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [SLOT_W-1:0]  s1_slot_reg;
    logic               s1_last_reg;

    // stage 2: bound check, row product
    logic               s2_valid_reg;
    logic               s2_outside_reg;
    logic [ELEM_W-1:0]  s2_x_reg;
    logic [ELEM_W-1:0]  s2_z_reg;
    logic [PLANE_W-1:0] s2_ysx_reg;
    logic [SLOT_W-1:0]  s2_slot_reg;
    logic               s2_last_reg;

    // output register
    logic               result_valid_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [SLOT_W-1:0]  local_slot_reg;
    logic               outside_reg;
    logic               last_reg;

    logic                      adv;
    logic                      gen_valid;
    logic                      gen_last;
    logic [COORD_W-1:0]        gen_x, gen_y, gen_z;
    logic                      s2_outside;
    logic [PLANE_W-1:0]        s2_ysx;
    logic [ELEM_W+PLANE_W-1:0] addr_sum;

    // whole pipeline moves unless the output beat is held
    assign adv       = !(result_valid_reg && result_stall);
    assign gen_valid = !empty;
    assign gen_last  = (i_reg == cfg.last_x) && (j_reg == cfg.last_y) && (k_reg == cfg.last_z);
    assign pop       = adv && gen_valid && gen_last;

    assign gen_x = {1'b0, head.base_x} + COORD_W'(i_reg);
    assign gen_y = {1'b0, head.base_y} + COORD_W'(j_reg);
    assign gen_z = {1'b0, head.base_z} + COORD_W'(k_reg);

    always_comb
    begin
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        slot_next = slot_reg;
        if (adv && gen_valid)
        begin
            slot_next = gen_last ? '0 : slot_reg + SLOT_W'(1);
            if (i_reg == cfg.last_x)
            begin
                i_next = '0;
                if (j_reg == cfg.last_y)
                begin
                    j_next = '0;
                    k_next = (k_reg == cfg.last_z) ? '0 : k_reg + CNT_W'(1);
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            else
            begin
                i_next = i_reg + CNT_W'(1);
            end
        end
    end

    assign s2_outside = (s1_x_reg >= COORD_W'(cfg.size_x)) ||
                        (s1_y_reg >= COORD_W'(cfg.size_y)) ||
                        (s1_z_reg >= COORD_W'(cfg.size_z));
    // inside points have coordinates below the grid limit, so the low bits suffice
    assign s2_ysx     = s1_y_reg[ELEM_W-1:0] * cfg.size_x;
    assign addr_sum   = (s2_z_reg * cfg.plane) + (ELEM_W+PLANE_W)'(s2_ysx_reg)
                      + (ELEM_W+PLANE_W)'(s2_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            slot_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg    <= i_next;
            j_reg    <= j_next;
            k_reg    <= k_next;
            slot_reg <= slot_next;
            if (adv)
            begin
                s1_valid_reg     <= gen_valid;
                s2_valid_reg     <= s1_valid_reg;
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg       <= gen_x;
            s1_y_reg       <= gen_y;
            s1_z_reg       <= gen_z;
            s1_slot_reg    <= slot_reg;
            s1_last_reg    <= gen_last;

            s2_outside_reg <= s2_outside;
            s2_x_reg       <= s1_x_reg[ELEM_W-1:0];
            s2_z_reg       <= s1_z_reg[ELEM_W-1:0];
            s2_ysx_reg     <= s2_ysx;
            s2_slot_reg    <= s1_slot_reg;
            s2_last_reg    <= s1_last_reg;

            address_reg    <= s2_outside_reg ? '0 : addr_sum[ADDR_W-1:0];
            local_slot_reg <= s2_slot_reg;
            outside_reg    <= s2_outside_reg;
            last_reg       <= s2_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign address      = address_reg;
    assign local_slot   = local_slot_reg;
    assign outside      = outside_reg;
    assign last         = last_reg;

    `FEGAG_ASSERT_NEXT(a_slot_restarts, adv && gen_valid && gen_last, slot_reg == '0)
    `FEGAG_ASSERT_IMPL(a_count_in_range, 1'b1,
        (i_reg <= cfg.last_x) && (j_reg <= cfg.last_y) && (k_reg <= cfg.last_z))
    `FEGAG_ASSERT_IMPL(a_outside_zero, result_valid_reg && outside_reg, address_reg == '0)

endmodule

`default_nettype wire

// ===== src/fe_element_gather_address_gen.sv =====
// Top level of the structured grid element gather address generator.
// Usage:
//   Element channel: item_valid/item_stall with element_x/y/z. One beat names
//   one hexahedral element; a beat is taken when item_valid is high and
//   item_stall is low. item_stall rises only when the four-entry element
//   queue is full.
//   Result channel: result_valid/result_stall with address, local_slot,
//   outside and last. Each element yields points_x*points_y*points_z beats,
//   x fastest, last marking the final point.
//   Pipeline: the first point of an element passes the queue, stage 1,
//   stage 2 and the output register. Throughput is one point per cycle
//   from the back end's point counter while the queue is not empty and
//   the output is not held, and queued elements follow with no gap.
//   Stall: result_stall with result_valid high freezes the address pipeline
//   with the held beat unchanged; the queue keeps taking elements until it fills.
//   Configuration: cfg_write/cfg_index/cfg_data, written while idle. The
//   plane stride product is registered from the size registers.
//   Reset: all counters and the queue clear; points 2, grid 1024, nodal.
`default_nettype none

module fe_element_gather_address_gen (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fegag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fegag_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [fegag_pkg::ELEM_W-1:0]        element_x,
    input  logic [fegag_pkg::ELEM_W-1:0]        element_y,
    input  logic [fegag_pkg::ELEM_W-1:0]        element_z,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [fegag_pkg::ADDR_W-1:0]        address,
    output logic [fegag_pkg::SLOT_W-1:0]        local_slot,
    output logic                                outside,
    output logic                                last
);
    import fegag_pkg::*;

    // raw register values; clamping happens on the read side
    logic [PTS_W-1:0]   points_x_reg, points_y_reg, points_z_reg;
    logic [GRID_W-1:0]  grid_size_x_reg, grid_size_y_reg, grid_size_z_reg;
    logic               tiled_mode_reg;
    logic [PLANE_W-1:0] plane_reg;

    logic [PTS_W-1:0]   pts_x, pts_y, pts_z;
    logic [GRID_W-1:0]  size_x, size_y, size_z;

    front_cfg_t front_cfg;
    back_cfg_t  back_cfg;
    elem_t      entry;
    elem_t      head;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_x_reg    <= PTS_W'(2);
            points_y_reg    <= PTS_W'(2);
            points_z_reg    <= PTS_W'(2);
            grid_size_x_reg <= GRID_W'(1024);
            grid_size_y_reg <= GRID_W'(1024);
            grid_size_z_reg <= GRID_W'(1024);
            tiled_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POINTS_X:    points_x_reg    <= cfg_data[PTS_W-1:0];
                REG_POINTS_Y:    points_y_reg    <= cfg_data[PTS_W-1:0];
                REG_POINTS_Z:    points_z_reg    <= cfg_data[PTS_W-1:0];
                REG_GRID_SIZE_X: grid_size_x_reg <= cfg_data[GRID_W-1:0];
                REG_GRID_SIZE_Y: grid_size_y_reg <= cfg_data[GRID_W-1:0];
                REG_GRID_SIZE_Z: grid_size_z_reg <= cfg_data[GRID_W-1:0];
                REG_TILED_MODE:  tiled_mode_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign pts_x  = clamp_points(points_x_reg);
    assign pts_y  = clamp_points(points_y_reg);
    assign pts_z  = clamp_points(points_z_reg);
    assign size_x = clamp_grid(grid_size_x_reg);
    assign size_y = clamp_grid(grid_size_y_reg);
    assign size_z = clamp_grid(grid_size_z_reg);

    // plane stride sx*sy, kept in a register so the back end sees one multiply per stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plane_reg <= '0;
        else
            plane_reg <= size_x * size_y;
    end

    assign front_cfg.pts_x = pts_x;
    assign front_cfg.pts_y = pts_y;
    assign front_cfg.pts_z = pts_z;
    assign front_cfg.tiled = tiled_mode_reg;

    // counters run to points-1
    assign back_cfg.last_x = CNT_W'(pts_x - PTS_W'(1));
    assign back_cfg.last_y = CNT_W'(pts_y - PTS_W'(1));
    assign back_cfg.last_z = CNT_W'(pts_z - PTS_W'(1));
    assign back_cfg.size_x = size_x;
    assign back_cfg.size_y = size_y;
    assign back_cfg.size_z = size_z;
    assign back_cfg.plane  = plane_reg;

    fegag_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .element_x  (element_x),
        .element_y  (element_y),
        .element_z  (element_z),
        .cfg        (front_cfg),
        .full       (full),
        .push       (push),
        .entry      (entry)
    );

    fegag_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (entry),
        .pop   (pop),
        .head  (head),
        .full  (full),
        .empty (empty)
    );

    fegag_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (back_cfg),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .address      (address),
        .local_slot   (local_slot),
        .outside      (outside),
        .last         (last)
    );

endmodule

`default_nettype wire
